// ----- src/skd_pkg.sv -----
// Shared types and constants for the scalar Kalman denoiser.
// Used by skd_ctrl, skd_datapath and scalar_kalman_denoiser_top; no dependencies.
package skd_pkg;

  // Number formats
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 31;
  localparam int EST_SHIFT   = 32 - SAMPLE_BITS;

  // Gain holds 0 .. 1.0, so it needs one integer bit
  localparam int GAIN_W = FRAC_BITS + 1;
  // Widest product: (1 - gain) * pred
  localparam int PROD_W = FRAC_BITS + 33;
  // Divider: numerator width, one quotient bit per step
  localparam int NUM_W     = FRAC_BITS + 33;
  localparam int DIV_STEPS = FRAC_BITS + 1;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [31:0]       COV_ONE  = 32'd1 << FRAC_BITS;
  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << FRAC_BITS;

  localparam logic [31:0] PV_RESET = 32'(21475 >> (31 - FRAC_BITS));
  localparam logic [31:0] MV_RESET = 32'(2630667 >> (31 - FRAC_BITS));

  // Configuration register indexes
  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PROCESS_VAR     = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MEASUREMENT_VAR = 2'd1;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRED,
    ST_SETUP,
    ST_DIV,
    ST_GAIN,
    ST_MUL_EST,
    ST_MUL_COV,
    ST_COV,
    ST_DONE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_in;   // latch sample, apply start request
    logic pred;      // predicted covariance
    logic setup;     // denominator and divider start
    logic div_step;  // one restoring division step
    logic gain;      // clamp quotient into gain
    logic mul_en;    // write the shared multiplier's product
    logic mul_cov;   // multiplier operands: (1 - gain) * pred
    logic upd_est;   // estimate update from product
    logic cov_upd;   // covariance update from product
    logic load_out;  // round estimate into output word
  } cmd_t;

endpackage

// ----- src/scalar_kalman_denoiser_top.sv -----
// Top level of the scalar Kalman denoiser: controller plus datapath.
// Depends on skd_pkg, skd_ctrl and skd_datapath.
//
//   channel  direction  handshake           word
//   in       input      in_valid/in_stall   sample, start_req
//   out      output     out_valid/out_stall filtered
//   cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// A word passes through prediction, then the gain divider, which retires one
// quotient bit a cycle (FRAC_BITS + 1 steps), then two passes through the
// shared multiplier and the updates.
// Reset restores the variance registers, estimate 0 and covariance 1.0.
// A stalled output word holds the next one in the controller; input is taken
// again once the result has moved into the output register.
module scalar_kalman_denoiser_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [skd_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                                  start_req,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [skd_pkg::SAMPLE_BITS-1:0] filtered,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [skd_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [31:0]                           cfg_data
);
  import skd_pkg::*;

  cmd_t cmd;

  // registers are always writable
  assign cfg_ready = 1'b1;

  skd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  skd_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sample    (sample),
    .start_req (start_req),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .filtered  (filtered)
  );

endmodule

// ----- src/skd_ctrl.sv -----
// Controller state machine of the scalar Kalman denoiser.
// Depends on skd_pkg; drives skd_datapath through cmd_t.
module skd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output skd_pkg::cmd_t cmd
);
  import skd_pkg::*;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] cnt;
  logic             div_last;
  logic             out_free;

  assign div_last = (cnt == CNT_W'(DIV_STEPS - 1));
  // output slot is empty or being taken this cycle
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  // state register and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_SETUP) begin
        cnt <= '0;
      end else if (state == ST_DIV) begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  // output word valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_PRED;
        end
      end
      ST_PRED: begin
        cmd.pred   = 1'b1;
        state_next = ST_SETUP;
      end
      ST_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (div_last) begin
          state_next = ST_GAIN;
        end
      end
      ST_GAIN: begin
        cmd.gain   = 1'b1;
        state_next = ST_MUL_EST;
      end
      ST_MUL_EST: begin
        cmd.mul_en = 1'b1;
        state_next = ST_MUL_COV;
      end
      ST_MUL_COV: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_cov = 1'b1;
        cmd.upd_est = 1'b1;
        state_next  = ST_COV;
      end
      ST_COV: begin
        cmd.cov_upd = 1'b1;
        state_next  = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- src/skd_datapath.sv -----
// Datapath of the scalar Kalman denoiser: variance registers, filter state,
// restoring divider for the gain, one shared 32x32 multiplier, output rounding.
// Depends on skd_pkg; commanded by skd_ctrl.
module skd_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  skd_pkg::cmd_t                         cmd,
  input  logic signed [skd_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                                  start_req,
  input  logic                                  cfg_wr,
  input  logic [skd_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [31:0]                           cfg_data,
  output logic signed [skd_pkg::SAMPLE_BITS-1:0] filtered
);
  import skd_pkg::*;

  // configuration and filter state
  logic [31:0]        pv;
  logic [31:0]        mv;
  logic signed [31:0] est;
  logic [31:0]        cov;

  // per-word working registers
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic [31:0]        pred;
  logic [32:0]        den;
  logic [32:0]        rem;
  logic [GAIN_W-1:0]  quo;    // numerator low bits, then quotient
  logic [GAIN_W-1:0]  gain;
  logic [PROD_W-1:0]  prod;

  // combinational terms
  logic [32:0]        pred_sum;
  logic [32:0]        den_c;
  logic [NUM_W-1:0]   num;
  logic [33:0]        rem_sh;
  logic               rem_ge;
  logic [33:0]        rem_sub;
  logic signed [32:0] diff;
  logic               diff_neg;
  logic [32:0]        diff_abs;
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [PROD_W:0]    prod_rnd;
  logic [32:0]        dmag;
  logic signed [33:0] delta;
  logic signed [33:0] est_sum;
  logic signed [31:0] est_new;
  logic [32:0]        emag;
  logic [32:0]        emag_rnd;
  logic [32-EST_SHIFT:0] omag;
  logic signed [SAMPLE_BITS-1:0] out_c;

  // predicted covariance, saturated to 32 bits
  assign pred_sum = {1'b0, cov} + {1'b0, pv};

  // gain numerator: pred * 2^F + den / 2
  assign den_c = {1'b0, pred} + {1'b0, mv};
  assign num   = {1'b0, pred, FRAC_BITS'(0)} + NUM_W'(den_c >> 1);

  // one restoring division step
  assign rem_sh  = {rem, quo[GAIN_W-1]};
  assign rem_ge  = (rem_sh >= {1'b0, den});
  assign rem_sub = rem_sh - {1'b0, den};

  // innovation: sample scaled to Q1.31 minus estimate
  assign diff     = 33'(signed'({sample_q, EST_SHIFT'(0)})) - 33'(est);
  assign diff_neg = diff[32];
  assign diff_abs = diff_neg ? 33'(-diff) : 33'(diff);

  // shared multiplier operands
  always_comb begin
    if (cmd.mul_cov) begin
      mul_a = 32'(GAIN_ONE - gain);
      mul_b = pred;
    end else begin
      mul_a = 32'(gain);
      mul_b = diff_abs[31:0];
    end
  end

  // product rounded to nearest at F fraction bits
  assign prod_rnd = {1'b0, prod} + (PROD_W + 1)'(COV_ONE >> 1);
  assign dmag     = 33'(prod_rnd >> FRAC_BITS);

  // new estimate with signed 32-bit saturation
  assign delta   = diff_neg ? -signed'({1'b0, dmag}) : signed'({1'b0, dmag});
  assign est_sum = 34'(est) + delta;
  always_comb begin
    if (est_sum > 34'sd2147483647) begin
      est_new = 32'sh7fffffff;
    end else if (est_sum < -34'sd2147483648) begin
      est_new = 32'sh80000000;
    end else begin
      est_new = est_sum[31:0];
    end
  end

  // output: estimate rounded to the sample format and saturated
  assign emag     = est[31] ? 33'(-33'(est)) : 33'(est);
  assign emag_rnd = emag + 33'(33'd1 << (EST_SHIFT - 1));
  assign omag     = emag_rnd[32:EST_SHIFT];
  always_comb begin
    if (!est[31]) begin
      if (omag > (33 - EST_SHIFT)'((1 << (SAMPLE_BITS - 1)) - 1)) begin
        out_c = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
      end else begin
        out_c = SAMPLE_BITS'(omag);
      end
    end else begin
      if (omag > (33 - EST_SHIFT)'(1 << (SAMPLE_BITS - 1))) begin
        out_c = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
      end else begin
        out_c = SAMPLE_BITS'(-omag);
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= PV_RESET;
      mv <= MV_RESET;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_PROCESS_VAR:     pv <= cfg_data;
        REG_MEASUREMENT_VAR: mv <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      est <= '0;
      cov <= COV_ONE;
    end else begin
      if (cmd.load_in && start_req) begin
        est <= '0;
        cov <= COV_ONE;
      end
      if (cmd.upd_est) begin
        est <= est_new;
      end
      if (cmd.cov_upd) begin
        cov <= 32'(prod_rnd >> FRAC_BITS);
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      sample_q <= sample;
    end
    if (cmd.pred) begin
      pred <= pred_sum[32] ? 32'hffffffff : pred_sum[31:0];
    end
    if (cmd.setup) begin
      den <= den_c;
      rem <= 33'(num >> GAIN_W);
      quo <= num[GAIN_W-1:0];
    end
    if (cmd.div_step) begin
      rem <= rem_ge ? rem_sub[32:0] : rem_sh[32:0];
      quo <= {quo[GAIN_W-2:0], rem_ge};
    end
    if (cmd.gain) begin
      if (den == '0) begin
        gain <= '0;
      end else if (quo > GAIN_ONE) begin
        gain <= GAIN_ONE;
      end else begin
        gain <= quo;
      end
    end
    if (cmd.mul_en) begin
      prod <= PROD_W'(mul_a * mul_b);
    end
    if (cmd.load_out) begin
      filtered <= out_c;
    end
  end

endmodule
